// ===== hdl/cam_pkg.sv =====
// Shared types and constants for the color affine matrix transform.
// Used by cam_lane, color_affine_matrix_transform, cam_props, cam_chk and tb.
package cam_pkg;

  localparam int CHAN_W   = 8;
  localparam int PIX_W    = 3 * CHAN_W;
  localparam int COEF_W   = 16;
  localparam int ROW_W    = 4 * COEF_W;
  localparam int PROD_W   = COEF_W + CHAN_W + 1;
  localparam int SUM_W    = 27;
  localparam int FRAC_W   = 12;
  localparam int OFS_SH   = 8;
  localparam int NUM_ROWS = 3;
  localparam int IDX_W    = 2;

  localparam logic [CHAN_W-1:0] CHAN_MAX = '1;
  localparam logic [SUM_W-1:0]  HALF_LSB = SUM_W'(1) << (FRAC_W - 1);

  typedef logic [IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_ROW_RED   = 2'd0;
  localparam cfg_idx_t REG_ROW_GREEN = 2'd1;
  localparam cfg_idx_t REG_ROW_BLUE  = 2'd2;

  localparam logic [ROW_W-1:0] ROW_RED_RST   = 64'h0000_0000_0000_1000;
  localparam logic [ROW_W-1:0] ROW_GREEN_RST = 64'h0000_0000_1000_0000;
  localparam logic [ROW_W-1:0] ROW_BLUE_RST  = 64'h0000_1000_0000_0000;

  typedef struct packed {
    logic signed [COEF_W-1:0] offset;
    logic signed [COEF_W-1:0] gain_b;
    logic signed [COEF_W-1:0] gain_g;
    logic signed [COEF_W-1:0] gain_r;
  } row_t;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } pix_t;

  // Per-stage load enables from the pipeline control in the top level
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

endpackage

// ===== hdl/color_affine_matrix_transform.sv =====
// An input transfer passes through the multiply, sum and round/clamp registers before reaching out_*.
// Throughput: one pixel per cycle while out_tready is high; three register stages (multiply,
// sum, round/clamp), each of which loads whenever it is empty or its successor moves.
// Reset (rst_n low, synchronous): stage valid bits clear, matrix rows return to identity.
// Top level of the color transform; depends on cam_pkg and cam_lane.
module color_affine_matrix_transform (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [cam_pkg::PIX_W-1:0] in_tdata,   // red_in, green_in, blue_in
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [cam_pkg::PIX_W-1:0] out_tdata,  // red_out, green_out, blue_out
  output logic                      out_tuser,  // clipped
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  cam_pkg::cfg_idx_t         cfg_index,
  input  logic [cam_pkg::ROW_W-1:0] cfg_data
);
  import cam_pkg::*;

  logic [ROW_W-1:0] row_red_r, row_green_r, row_blue_r;
  logic             v1_r, v2_r, v3_r;
  logic             v1_nxt, v2_nxt, v3_nxt;
  logic             rdy1, rdy2, rdy3;
  stage_en_t        en;
  pix_t             pix;
  logic [CHAN_W-1:0] chan_red, chan_green, chan_blue;
  logic              clip_red, clip_green, clip_blue;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_red_r   <= ROW_RED_RST;
      row_green_r <= ROW_GREEN_RST;
      row_blue_r  <= ROW_BLUE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ROW_RED:   row_red_r   <= cfg_data;
        REG_ROW_GREEN: row_green_r <= cfg_data;
        REG_ROW_BLUE:  row_blue_r  <= cfg_data;
        default: ;  // drop writes past the last row
      endcase
    end
  end

  // A stage advances when it is empty or the next one takes its item
  always_comb begin
    rdy3   = !v3_r || out_tready;
    rdy2   = !v2_r || rdy3;
    rdy1   = !v1_r || rdy2;
    en.s1  = rdy1;
    en.s2  = rdy2;
    en.s3  = rdy3;
    v1_nxt = rdy1 ? in_tvalid : v1_r;
    v2_nxt = rdy2 ? v1_r : v2_r;
    v3_nxt = rdy3 ? v2_r : v3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  assign pix = pix_t'(in_tdata);

  cam_lane u_lane_red (
    .clk    (clk),
    .row    (row_t'(row_red_r)),
    .pix    (pix),
    .en     (en),
    .chan_q (chan_red),
    .clip_q (clip_red)
  );

  cam_lane u_lane_green (
    .clk    (clk),
    .row    (row_t'(row_green_r)),
    .pix    (pix),
    .en     (en),
    .chan_q (chan_green),
    .clip_q (clip_green)
  );

  cam_lane u_lane_blue (
    .clk    (clk),
    .row    (row_t'(row_blue_r)),
    .pix    (pix),
    .en     (en),
    .chan_q (chan_blue),
    .clip_q (clip_blue)
  );

  assign in_tready  = rdy1;
  assign out_tvalid = v3_r;
  assign out_tdata  = {chan_blue, chan_green, chan_red};
  assign out_tuser  = clip_red || clip_green || clip_blue;

endmodule

// ===== hdl/cam_lane.sv =====
// One output channel of the transform: multiply, sum, round and clamp.
// Three register stages; loads are steered by the top level. Depends on cam_pkg.
module cam_lane (
  input  logic                       clk,
  input  cam_pkg::row_t              row,
  input  cam_pkg::pix_t              pix,
  input  cam_pkg::stage_en_t         en,
  output logic [cam_pkg::CHAN_W-1:0] chan_q,
  output logic                       clip_q
);
  import cam_pkg::*;

  logic signed [PROD_W-1:0] prod_r_r, prod_g_r, prod_b_r;
  logic signed [PROD_W-1:0] prod_r_nxt, prod_g_nxt, prod_b_nxt;
  logic signed [COEF_W-1:0] ofs_r;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CHAN_W-1:0]        chan_r, chan_nxt;
  logic                     clip_r, clip_nxt;
  logic [SUM_W-FRAC_W-2:0]  quo;

  // Stage 1: signed gain times zero-extended channel
  always_comb begin
    prod_r_nxt = PROD_W'(row.gain_r) * PROD_W'($signed({1'b0, pix.red}));
    prod_g_nxt = PROD_W'(row.gain_g) * PROD_W'($signed({1'b0, pix.green}));
    prod_b_nxt = PROD_W'(row.gain_b) * PROD_W'($signed({1'b0, pix.blue}));
  end

  // Stage 2: exact Q.12 sum, offset aligned by 8, plus one half for rounding
  always_comb begin
    sum_nxt = SUM_W'(prod_r_r) + SUM_W'(prod_g_r) + SUM_W'(prod_b_r)
            + (SUM_W'(ofs_r) <<< OFS_SH)
            + $signed(HALF_LSB);
  end

  // Stage 3: floor by 4096, clamp to channel range
  always_comb begin
    quo      = sum_r[SUM_W-2:FRAC_W];
    chan_nxt = quo[CHAN_W-1:0];
    clip_nxt = 1'b0;
    if (sum_r[SUM_W-1]) begin
      chan_nxt = '0;
      clip_nxt = 1'b1;
    end else if (|quo[SUM_W-FRAC_W-2:CHAN_W]) begin
      chan_nxt = CHAN_MAX;
      clip_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      prod_r_r <= prod_r_nxt;
      prod_g_r <= prod_g_nxt;
      prod_b_r <= prod_b_nxt;
      ofs_r    <= row.offset;
    end
    if (en.s2) begin
      sum_r <= sum_nxt;
    end
    if (en.s3) begin
      chan_r <= chan_nxt;
      clip_r <= clip_nxt;
    end
  end

  assign chan_q = chan_r;
  assign clip_q = clip_r;

endmodule

// ===== hdl/cam_chk.sv =====
// Port-level checker for the color transform, bound to the top level.
// Depends on cam_pkg.
module cam_props (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [cam_pkg::PIX_W-1:0] out_tdata,
  input logic                      out_tuser
);
  import cam_pkg::*;

  logic [CHAN_W-1:0] o_red, o_green, o_blue;

  assign o_red   = out_tdata[CHAN_W-1:0];
  assign o_green = out_tdata[2*CHAN_W-1:CHAN_W];
  assign o_blue  = out_tdata[3*CHAN_W-1:2*CHAN_W];

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A clip flag always comes with a channel at one of the rails
  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      o_red == '0 || o_red == CHAN_MAX || o_green == '0 || o_green == CHAN_MAX ||
      o_blue == '0 || o_blue == CHAN_MAX)
    else $error("clip flag without a clamped channel");

  // With out_tready held high after a transfer, the result comes out once it has passed every stage
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && out_tready) ##1 out_tready ##1 out_tready |=> out_tvalid)
    else $error("result missing three cycles after input transfer");

endmodule

bind color_affine_matrix_transform cam_props u_cam_chk (.*);

// ===== dv/cam_chk.sv =====
// Checker for color_affine_matrix_transform: mirrors the matrix rows from config
// transfers, predicts each output pixel and compares results in order.
// Depends on cam_pkg.
module cam_chk (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  input  logic                      in_tready,
  input  logic [cam_pkg::PIX_W-1:0] in_tdata,   // red_in, green_in, blue_in
  input  logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic [cam_pkg::PIX_W-1:0] out_tdata,  // red_out, green_out, blue_out
  input  logic                      out_tuser,  // clipped
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  cam_pkg::cfg_idx_t         cfg_index,
  input  logic [cam_pkg::ROW_W-1:0] cfg_data,
  output int                        fail_count,
  output int                        pending
);
  import cam_pkg::*;

  typedef struct packed {
    logic clipped;
    pix_t pix;
  } cam_result_t;

  row_t        matrix [NUM_ROWS];
  cam_result_t expected_pixels [$];
  int          mismatches = 0;

  // Exact Q.12 sum plus one half, then floor and clamp; the top bit flags a clamp
  function automatic logic [CHAN_W:0] affine_channel(row_t row, pix_t px);
    int acc;
    acc = int'(row.gain_r) * int'(px.red)
        + int'(row.gain_g) * int'(px.green)
        + int'(row.gain_b) * int'(px.blue)
        + int'(row.offset) * (1 << OFS_SH)
        + (1 << (FRAC_W - 1));
    if (acc < 0)
      return {1'b1, {CHAN_W{1'b0}}};
    acc = acc >>> FRAC_W;
    if (acc > int'(CHAN_MAX))
      return {1'b1, CHAN_MAX};
    return {1'b0, acc[CHAN_W-1:0]};
  endfunction

  function automatic cam_result_t transform_pixel(pix_t px);
    cam_result_t     res;
    logic [CHAN_W:0] r;
    logic [CHAN_W:0] g;
    logic [CHAN_W:0] b;
    r = affine_channel(matrix[REG_ROW_RED], px);
    g = affine_channel(matrix[REG_ROW_GREEN], px);
    b = affine_channel(matrix[REG_ROW_BLUE], px);
    res.pix.red   = r[CHAN_W-1:0];
    res.pix.green = g[CHAN_W-1:0];
    res.pix.blue  = b[CHAN_W-1:0];
    res.clipped   = r[CHAN_W] | g[CHAN_W] | b[CHAN_W];
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    cam_result_t want;
    pix_t        got;
    if (!rst_n) begin
      matrix[REG_ROW_RED]   = ROW_RED_RST;
      matrix[REG_ROW_GREEN] = ROW_GREEN_RST;
      matrix[REG_ROW_BLUE]  = ROW_BLUE_RST;
      expected_pixels.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROW_RED:   matrix[REG_ROW_RED]   = cfg_data;
          REG_ROW_GREEN: matrix[REG_ROW_GREEN] = cfg_data;
          REG_ROW_BLUE:  matrix[REG_ROW_BLUE]  = cfg_data;
          default: ;  // unmapped index: drop the write
        endcase
      end
      // compare before pushing so a result can never match its own input transfer
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_pixels.size() == 0) begin
          $error("result with no pixel pending: tdata %h, clipped %0d", out_tdata, out_tuser);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          if (got.red !== want.pix.red) begin
            $error("red_out mismatch: expected %0d, actual %0d", want.pix.red, got.red);
            mismatches++;
          end
          if (got.green !== want.pix.green) begin
            $error("green_out mismatch: expected %0d, actual %0d", want.pix.green, got.green);
            mismatches++;
          end
          if (got.blue !== want.pix.blue) begin
            $error("blue_out mismatch: expected %0d, actual %0d", want.pix.blue, got.blue);
            mismatches++;
          end
          if (out_tuser !== want.clipped) begin
            $error("clipped mismatch: expected %0d, actual %0d", want.clipped, out_tuser);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_pixels.push_back(transform_pixel(in_tdata));
    end
    fail_count <= mismatches;
    pending    <= expected_pixels.size();
  end

endmodule

// ===== dv/tb.sv =====
// Testbench top for color_affine_matrix_transform: drives pixels and matrix rows,
// stalls both stream sides at random and reports the verdict.
// Depends on cam_pkg, the block and cam_chk.
module tb;
  import cam_pkg::*;

  localparam cfg_idx_t REG_UNMAPPED     = 2'd3;
  localparam int       WATCHDOG_LIMIT   = 1000;
  localparam int       HOLD_CYCLES      = 150;
  localparam int       DRAIN_CYCLES     = 8;
  localparam int       RANDOM_PHASES    = 8;
  localparam int       PIXELS_PER_PHASE = 135;

  localparam row_t EDGE_ROW_RED   = 64'hFFF8_0000_F000_1000;  // r - g - 0.5
  localparam row_t EDGE_ROW_GREEN = 64'h0008_0000_1000_0000;  // g + 0.5
  localparam row_t MAX_POS_ROW    = 64'h7FFF_7FFF_7FFF_7FFF;
  localparam row_t MAX_NEG_ROW    = 64'h8000_8000_8000_8000;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [PIX_W-1:0] in_tdata   = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [PIX_W-1:0] out_tdata;
  logic             out_tuser;
  logic             cfg_valid  = 1'b0;
  logic             cfg_ready;
  cfg_idx_t         cfg_index  = REG_ROW_RED;
  logic [ROW_W-1:0] cfg_data   = '0;

  int fail_count;
  int pending;
  int squeeze_req  = 0;
  int squeeze_done = 0;
  bit steady_feed  = 1'b0;

  color_affine_matrix_transform i_dut (.*);

  cam_chk i_chk (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic pix_t rgb(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                               logic [CHAN_W-1:0] b);
    return '{blue: b, green: g, red: r};
  endfunction

  function automatic logic [CHAN_W-1:0] edge_byte(logic [CHAN_W-1:0] v);
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return CHAN_MAX;
      default: return v;
    endcase
  endfunction

  function automatic pix_t random_pixel();
    pix_t px;
    px = pix_t'(PIX_W'($urandom));
    if ($urandom_range(0, 5) == 0) begin
      px.red   = edge_byte(px.red);
      px.green = edge_byte(px.green);
      px.blue  = edge_byte(px.blue);
    end
    return px;
  endfunction

  function automatic logic [COEF_W-1:0] extreme_coef();
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h7FFF;
      default: return 16'h8000;
    endcase
  endfunction

  // Mostly moderate gains and offsets so outputs land inside 0..255 often
  function automatic row_t random_row();
    row_t              row;
    logic [COEF_W-1:0] coef;
    case ($urandom_range(0, 9))
      0, 1: row = {$urandom, $urandom};
      2: begin
        coef = extreme_coef();
        row  = {4{coef}};
      end
      3: row = {extreme_coef(), extreme_coef(), extreme_coef(), extreme_coef()};
      default: begin
        row.gain_r = COEF_W'(int'($urandom_range(0, 12288)) - 6144);
        row.gain_g = COEF_W'(int'($urandom_range(0, 12288)) - 6144);
        row.gain_b = COEF_W'(int'($urandom_range(0, 12288)) - 6144);
        row.offset = COEF_W'(int'($urandom_range(0, 4096)) - 2048);
      end
    endcase
    return row;
  endfunction

  function automatic int next_gap();
    int sel;
    if (steady_feed)
      return 0;
    sel = $urandom_range(0, 99);
    if (sel < 60)
      return 0;
    if (sel < 90)
      return $urandom_range(1, 3);
    if (sel < 97)
      return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Leave tvalid high on return; the next call or a drain decides what follows
  task automatic send_pixel(pix_t px);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain_pipeline();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_row(cfg_idx_t idx, logic [ROW_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_matrix(row_t r, row_t g, row_t b, bit poke_unmapped);
    drain_pipeline();
    write_row(REG_ROW_RED, r);
    write_row(REG_ROW_GREEN, g);
    write_row(REG_ROW_BLUE, b);
    if (poke_unmapped)
      write_row(REG_UNMAPPED, {$urandom, $urandom});
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // identity matrix out of reset
    send_pixel(rgb(8'd0, 8'd0, 8'd0));
    send_pixel(rgb(8'd255, 8'd255, 8'd255));
    send_pixel(rgb(8'd255, 8'd0, 8'd0));
    send_pixel(rgb(8'd0, 8'd255, 8'd0));
    send_pixel(rgb(8'd0, 8'd0, 8'd255));
    send_pixel(rgb(8'h5A, 8'hA5, 8'h3C));

    // half-step offsets to hit the rounding and clamp boundaries
    load_matrix(EDGE_ROW_RED, EDGE_ROW_GREEN, ROW_BLUE_RST, 1'b1);
    send_pixel(rgb(8'd0, 8'd0, 8'd0));      // red rounds to exactly zero
    send_pixel(rgb(8'd0, 8'd1, 8'd0));      // red below zero
    send_pixel(rgb(8'd255, 8'd0, 8'd0));    // red rounds up to exactly 255
    send_pixel(rgb(8'd0, 8'd255, 8'd0));    // green above range, red below zero
    send_pixel(rgb(8'd255, 8'd254, 8'd7));  // green exactly 255
    send_pixel(rgb(8'd128, 8'd64, 8'd200));

    load_matrix(MAX_POS_ROW, MAX_POS_ROW, MAX_POS_ROW, 1'b0);
    send_pixel(rgb(8'd255, 8'd255, 8'd255));
    send_pixel(rgb(8'd0, 8'd0, 8'd0));
    send_pixel(rgb(8'd1, 8'd0, 8'd0));

    load_matrix(MAX_NEG_ROW, MAX_NEG_ROW, MAX_NEG_ROW, 1'b0);
    send_pixel(rgb(8'd255, 8'd255, 8'd255));
    send_pixel(rgb(8'd0, 8'd0, 8'd0));
    send_pixel(rgb(8'd1, 8'd0, 8'd0));

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      load_matrix(random_row(), random_row(), random_row(), $urandom_range(0, 3) == 0);
      steady_feed = (ph == 1) || ($urandom_range(0, 3) == 0);
      // back the pipeline up against a long receiver hold-off
      if (ph == 1)
        squeeze_req++;
      for (int n = 0; n < PIXELS_PER_PHASE; n++)
        send_pixel(random_pixel());
    end

    drain_pipeline();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Receiver: random ready pattern, plus one long hold-off on request
  initial begin
    int sel;
    int run;
    forever begin
      if (squeeze_req != squeeze_done) begin
        squeeze_done++;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 10) begin
          out_tready <= 1'b1;
          run = $urandom_range(60, 200);
        end else if (sel < 45) begin
          out_tready <= 1'b1;
          run = $urandom_range(1, 30);
        end else if (sel < 85) begin
          out_tready <= 1'b0;
          run = $urandom_range(1, 3);
        end else if (sel < 96) begin
          out_tready <= 1'b0;
          run = $urandom_range(4, 10);
        end else begin
          out_tready <= 1'b0;
          run = $urandom_range(20, 40);
        end
        // cut the run short so a hold-off starts while the sender is still busy
        repeat (run) begin
          @(posedge clk);
          if (squeeze_req != squeeze_done)
            break;
        end
      end
    end
  end

  // Watchdog: give up after a long stretch with no transfer on any channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/cam_pkg.sv
hdl/cam_lane.sv
hdl/color_affine_matrix_transform.sv
hdl/cam_chk.sv
dv/cam_chk.sv
dv/tb.sv
